FILE: hw/rtl/whm_pkg.sv
// Shared widths, payload structs, status codes and divider request type for the harmonic mean block.
package whm_pkg;

  localparam int VAL_W     = 16;
  localparam int WGT_W     = 16;
  localparam int MEAN_W    = 16;
  localparam int FRAC_SH   = 24;
  localparam int MAX_ITEMS = 1024;

  localparam int Q_W    = VAL_W + FRAC_SH;
  localparam int WT_W   = WGT_W + $clog2(MAX_ITEMS);
  localparam int RT_W   = Q_W + $clog2(MAX_ITEMS);
  localparam int STEP_W = $clog2(RT_W + 1);
  localparam int OVF_SH = FRAC_SH - MEAN_W;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_VAL  = 2'd1,
    ST_ZERO_RECIP = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [WGT_W-1:0] weight;
    logic             last_item;
  } whm_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    status_t           status;
  } whm_out_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [RT_W-1:0]   rem_init;
    logic [RT_W-1:0]   dividend;
    logic [RT_W-1:0]   divisor;
  } div_req_t;

endpackage

FILE: hw/rtl/whm_div.sv
// Radix-2 restoring divider: one quotient bit per cycle, shared by both divisions.
module whm_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  whm_pkg::div_req_t       req_i,
  output logic                    done_o,
  output logic [whm_pkg::Q_W-1:0] quot_o
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [whm_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [whm_pkg::RT_W-1:0]   rem_r, rem_nxt;
  logic [whm_pkg::RT_W-1:0]   dvd_r, dvd_nxt;
  logic [whm_pkg::RT_W-1:0]   dsr_r, dsr_nxt;
  logic [whm_pkg::Q_W-1:0]    quot_r, quot_nxt;

  logic [whm_pkg::RT_W:0]     trial;
  logic [whm_pkg::RT_W+1:0]   diff;
  logic                       ge;

  // Shift in the next dividend bit and try a subtract.
  assign trial = {rem_r, dvd_r[whm_pkg::RT_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_r};
  assign ge    = ~diff[whm_pkg::RT_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    quot_nxt = quot_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req_i.steps;
      rem_nxt  = req_i.rem_init;
      dvd_nxt  = req_i.dividend;
      dsr_nxt  = req_i.divisor;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[whm_pkg::RT_W-1:0] : trial[whm_pkg::RT_W-1:0];
      dvd_nxt  = {dvd_r[whm_pkg::RT_W-2:0], 1'b0};
      quot_nxt = {quot_r[whm_pkg::Q_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == whm_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    quot_r <= quot_nxt;
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

FILE: hw/rtl/weighted_harmonic_mean.sv
// Top level: weighted harmonic mean over a series of (value, weight) transactions.
//
// Input channel (in_valid/in_ready/in_data): one (value Q8.8, weight, last_item)
// transaction at a time. in_ready is high only while the sequencer is idle.
// Output channel (out_valid/out_ready/out_data): one (mean Q8.8, status)
// transaction per series, produced after the transaction marked last_item.
//
// Timing: for an item with a nonzero value, the accept cycle loads the shared
// radix-2 divider, which produces weight*2^24/value one quotient bit at a time;
// the quotient is then accumulated into the totals and in_ready returns. A zero
// value skips the divider. A last item adds a check state, then the divider
// computes weight_total*2^24/reciprocal_total, the quotient is captured and the
// output register is loaded; the final divide is skipped when the mean is out
// of range or the reciprocal total is zero.
// The output register decouples the two sides: the next series is accepted
// while a result waits; a second result waits until the first is taken.
// Reset (rst_n low, synchronous) clears both totals, the flags, the sequencer
// and out_valid.
module weighted_harmonic_mean (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  whm_pkg::whm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output whm_pkg::whm_out_t out_data
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ITEM_DIV = 6'b000010,
    S_CHECK    = 6'b000100,
    S_MEAN_DIV = 6'b001000,
    S_EMIT     = 6'b010000,
    S_SPARE    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Series state.
  logic [whm_pkg::WT_W-1:0]   wt_r, wt_nxt;
  logic [whm_pkg::RT_W-1:0]   rt_r, rt_nxt;
  logic                       zero_r, zero_nxt;
  logic                       sat_r, sat_nxt;

  // Item and result holding.
  logic [whm_pkg::WGT_W-1:0]  wgt_r, wgt_nxt;
  logic                       last_r, last_nxt;
  whm_pkg::whm_out_t          res_r, res_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  whm_pkg::whm_out_t          out_data_r, out_data_nxt;

  whm_pkg::div_req_t          div_req;
  logic                       div_done;
  logic [whm_pkg::Q_W-1:0]    div_quot;

  logic [whm_pkg::WT_W:0]     wt_sum;
  logic [whm_pkg::RT_W:0]     rt_sum;
  logic [whm_pkg::RT_W-1:0]   wt_scaled;
  logic                       in_acc;
  logic                       out_free;

  whm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // Saturating totals: the carry out marks overflow.
  assign wt_sum = {1'b0, wt_r} + {{(whm_pkg::WT_W + 1 - whm_pkg::WGT_W){1'b0}}, wgt_r};
  assign rt_sum = {1'b0, rt_r} + {{(whm_pkg::RT_W + 1 - whm_pkg::Q_W){1'b0}}, div_quot};

  // weight_total * 2^8: mean >= 2^16 exactly when this reaches reciprocal_total.
  assign wt_scaled = {{(whm_pkg::RT_W - whm_pkg::WT_W - whm_pkg::OVF_SH){1'b0}}, wt_r,
                      {whm_pkg::OVF_SH{1'b0}}};

  always_comb begin
    state_nxt     = state_r;
    wt_nxt        = wt_r;
    rt_nxt        = rt_r;
    zero_nxt      = zero_r;
    sat_nxt       = sat_r;
    wgt_nxt       = wgt_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_data.last_item;
          wgt_nxt  = in_data.weight;
          if (in_data.value == '0) begin
            // Skip the whole item, weight included.
            zero_nxt  = 1'b1;
            state_nxt = in_data.last_item ? S_CHECK : S_IDLE;
          end else begin
            div_req.start    = 1'b1;
            div_req.steps    = whm_pkg::STEP_W'(whm_pkg::Q_W);
            div_req.rem_init = '0;
            div_req.dividend = {in_data.weight, {whm_pkg::FRAC_SH{1'b0}},
                                {(whm_pkg::RT_W - whm_pkg::Q_W){1'b0}}};
            div_req.divisor  = {{(whm_pkg::RT_W - whm_pkg::VAL_W){1'b0}}, in_data.value};
            state_nxt        = S_ITEM_DIV;
          end
        end
      end
      S_ITEM_DIV: begin
        if (div_done) begin
          // Fold the reciprocal term and weight in, clamping at full scale.
          if (wt_sum[whm_pkg::WT_W]) begin
            wt_nxt  = '1;
            sat_nxt = 1'b1;
          end else begin
            wt_nxt = wt_sum[whm_pkg::WT_W-1:0];
          end
          if (rt_sum[whm_pkg::RT_W]) begin
            rt_nxt  = '1;
            sat_nxt = 1'b1;
          end else begin
            rt_nxt = rt_sum[whm_pkg::RT_W-1:0];
          end
          state_nxt = last_r ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        priority if (rt_r == '0) begin
          res_nxt.mean   = '0;
          res_nxt.status = whm_pkg::ST_ZERO_RECIP;
          state_nxt      = S_EMIT;
        end else if (wt_scaled >= rt_r) begin
          res_nxt.mean   = '1;
          res_nxt.status = whm_pkg::ST_SATURATED;
          state_nxt      = S_EMIT;
        end else begin
          // Top quotient bits are known zero: start from remainder wt*2^8.
          div_req.start    = 1'b1;
          div_req.steps    = whm_pkg::STEP_W'(whm_pkg::MEAN_W);
          div_req.rem_init = wt_scaled;
          div_req.dividend = '0;
          div_req.divisor  = rt_r;
          state_nxt        = S_MEAN_DIV;
        end
      end
      S_MEAN_DIV: begin
        if (div_done) begin
          res_nxt.mean = div_quot[whm_pkg::MEAN_W-1:0];
          priority if (sat_r) begin
            res_nxt.status = whm_pkg::ST_SATURATED;
          end else if (zero_r) begin
            res_nxt.status = whm_pkg::ST_ZERO_VAL;
          end else begin
            res_nxt.status = whm_pkg::ST_OK;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold the result until the output register frees, then clear the series.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          wt_nxt        = '0;
          rt_nxt        = '0;
          zero_nxt      = 1'b0;
          sat_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wt_r        <= '0;
      rt_r        <= '0;
      zero_r      <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wt_r        <= wt_nxt;
      rt_r        <= rt_nxt;
      zero_r      <= zero_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wgt_r      <= wgt_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Divider completion only shows up while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_ITEM_DIV || state_r == S_MEAN_DIV))
    else $error("divider done outside a divide state");

  // Emitting a result clears the series totals.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (wt_r == '0 && rt_r == '0 && !zero_r && !sat_r))
    else $error("series state not cleared after emit");

  // A zero reciprocal total always reports a zero mean.
  a_zero_recip_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == whm_pkg::ST_ZERO_RECIP) |-> (out_data.mean == '0))
    else $error("zero reciprocal status with nonzero mean");

  // No new item is taken while the divider works.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITEM_DIV || state_r == S_MEAN_DIV) |-> !in_ready)
    else $error("input ready during divide");

endmodule

FILE: test/tb_weighted_harmonic_mean.sv
// Testbench for weighted_harmonic_mean: directed and random series, checked against a predictor.
`timescale 1ns / 100ps

module tb_weighted_harmonic_mean;

  // Cap on cycles with no transaction on either channel.
  localparam int WATCHDOG_LIMIT = 2000;
  // Enough cycles for one item plus a final divide and the output load.
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_ITEMS   = 45;   // per idling phase, four phases
  localparam int SAT_ITEMS      = 1026; // one past the item that first saturates

  localparam logic [63:0] WEIGHT_CAP = (64'd1 << whm_pkg::WT_W) - 64'd1;
  localparam logic [63:0] RECIP_CAP  = (64'd1 << whm_pkg::RT_W) - 64'd1;
  localparam logic [63:0] MEAN_CAP   = (64'd1 << whm_pkg::MEAN_W) - 64'd1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  whm_pkg::whm_in_t  in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  whm_pkg::whm_out_t out_data;

  weighted_harmonic_mean DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Idling knobs, percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Predicted series state.
  logic [whm_pkg::WT_W-1:0] weight_sum;
  logic [whm_pkg::RT_W-1:0] recip_sum;
  logic                     zero_seen;
  logic                     sum_clipped;

  // Means predicted but not yet seen on the result channel, oldest first.
  whm_pkg::whm_out_t expected_means[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void clear_series();
    weight_sum  = '0;
    recip_sum   = '0;
    zero_seen   = 1'b0;
    sum_clipped = 1'b0;
  endfunction

  // Fold one item into the series; return 1 with the mean when it closes the series.
  function automatic bit fold_item(input whm_pkg::whm_in_t item,
                                   output whm_pkg::whm_out_t mean_out);
    logic [63:0] total;
    logic [63:0] term;
    logic [63:0] quotient;
    logic        over;
    mean_out = '0;
    if (item.value == '0) begin
      zero_seen = 1'b1;
    end else begin
      total = 64'(weight_sum) + 64'(item.weight);
      if (total > WEIGHT_CAP) begin
        sum_clipped = 1'b1;
        weight_sum  = WEIGHT_CAP[whm_pkg::WT_W-1:0];
      end else begin
        weight_sum = total[whm_pkg::WT_W-1:0];
      end
      term  = (64'(item.weight) << whm_pkg::FRAC_SH) / 64'(item.value);
      total = 64'(recip_sum) + term;
      if (total > RECIP_CAP) begin
        sum_clipped = 1'b1;
        recip_sum   = RECIP_CAP[whm_pkg::RT_W-1:0];
      end else begin
        recip_sum = total[whm_pkg::RT_W-1:0];
      end
    end
    if (!item.last_item) begin
      return 1'b0;
    end
    if (recip_sum == '0) begin
      mean_out.mean   = '0;
      mean_out.status = whm_pkg::ST_ZERO_RECIP;
    end else begin
      quotient      = (64'(weight_sum) << whm_pkg::FRAC_SH) / 64'(recip_sum);
      over          = quotient > MEAN_CAP;
      mean_out.mean = over ? MEAN_CAP[whm_pkg::MEAN_W-1:0] : quotient[whm_pkg::MEAN_W-1:0];
      if (over || sum_clipped) begin
        mean_out.status = whm_pkg::ST_SATURATED;
      end else if (zero_seen) begin
        mean_out.status = whm_pkg::ST_ZERO_VAL;
      end else begin
        mean_out.status = whm_pkg::ST_OK;
      end
    end
    clear_series();
    return 1'b1;
  endfunction

  // Drive one transaction and hold it until accepted. Valid stays high on return so
  // back-to-back items need no second assignment in the same step; anything else
  // that advances time must drop valid first.
  task automatic send_item(input logic [whm_pkg::VAL_W-1:0] value,
                           input logic [whm_pkg::WGT_W-1:0] weight,
                           input logic last);
    whm_pkg::whm_in_t  item;
    whm_pkg::whm_out_t mean_out;
    item.value     = value;
    item.weight    = weight;
    item.last_item = last;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (fold_item(item, mean_out)) begin
      expected_means.push_back(mean_out);
    end
  endtask

  // Drop valid, wait for every outstanding mean, then let the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Check each result transaction against the oldest prediction; randomize ready.
  always @(posedge clk) begin
    whm_pkg::whm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        report_mismatch($sformatf("unexpected result mean=%h status=%0d",
                                  out_data.mean, out_data.status));
      end else begin
        want = expected_means.pop_front();
        if (out_data.mean !== want.mean) begin
          report_mismatch($sformatf("mean %h, expected %h", out_data.mean, want.mean));
        end
        if (out_data.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Plain series: unity, extremes of both fields, a mixed three-item series and a two-item series.
  task automatic test_plain_series();
    send_item(16'h0100, 16'd1, 1'b1);
    send_item(16'h0001, 16'hFFFF, 1'b1);
    send_item(16'h0001, 16'd1, 1'b1);
    send_item(16'h0200, 16'd3, 1'b0);
    send_item(16'h0080, 16'd5, 1'b0);
    send_item(16'h1234, 16'h00FF, 1'b1);
    send_item(16'h7FFF, 16'h8000, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b1);
  endtask

  // Zero value: skip the item, flag the series; also as the closing item.
  task automatic test_zero_values();
    send_item(16'h0300, 16'd2, 1'b0);
    send_item(16'h0000, 16'hFFFF, 1'b0);
    send_item(16'h0100, 16'd4, 1'b1);
    send_item(16'h0400, 16'd7, 1'b0);
    send_item(16'h0000, 16'd9, 1'b1);
  endtask

  // Zero reciprocal sum: only zero values or zero weights in the series.
  task automatic test_zero_reciprocal();
    send_item(16'h0000, 16'd5, 1'b1);
    send_item(16'h0100, 16'd0, 1'b1);
    send_item(16'hFFFF, 16'd0, 1'b0);
    send_item(16'h0000, 16'd0, 1'b1);
  endtask

  // Quotient above 16 bits: clip the mean, saturated status wins over zero value.
  task automatic test_mean_overflow();
    send_item(16'hFFFF, 16'd1, 1'b1);
    send_item(16'hFFFF, 16'hFFFF, 1'b1);
    send_item(16'h0000, 16'd3, 1'b0);
    send_item(16'hFFFF, 16'd1, 1'b1);
  endtask

  // Total saturation: full weight on the smallest value drives both totals past
  // full scale, then one more item lands on the clamped totals.
  task automatic test_total_saturation();
    for (int i = 0; i < SAT_ITEMS; i++) begin
      send_item(16'h0001, 16'hFFFF, i == SAT_ITEMS - 1);
    end
  endtask

  function automatic logic [whm_pkg::VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 12) return 16'h0001;
    if (roll < 16) return 16'hFFFF;
    if (roll < 20) return 16'h0100;
    if (roll < 38) return whm_pkg::VAL_W'($urandom_range(1, 16'h03FF));
    return whm_pkg::VAL_W'($urandom);
  endfunction

  function automatic logic [whm_pkg::WGT_W-1:0] pick_weight();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return 16'hFFFF;
    if (roll < 40) return whm_pkg::WGT_W'($urandom_range(1, 16));
    return whm_pkg::WGT_W'($urandom);
  endfunction

  // Random series of random length; most short, some long.
  task automatic run_random_series(input int item_count);
    int sent;
    int series_len;
    int roll;
    sent = 0;
    while (sent < item_count) begin
      roll = $urandom_range(99);
      if (roll < 70) series_len = $urandom_range(1, 6);
      else if (roll < 95) series_len = $urandom_range(7, 30);
      else series_len = $urandom_range(31, 120);
      if (series_len > item_count - sent) series_len = item_count - sent;
      for (int i = 0; i < series_len; i++) begin
        send_item(pick_value(), pick_weight(), i == series_len - 1);
      end
      sent += series_len;
    end
  endtask

  // Random traffic under each idling mix; drain fully between mixes.
  task automatic test_random_traffic();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_series(RANDOM_ITEMS);
    wait_drained();
    send_idle_pct  = 62;
    recv_stall_pct = 0;
    run_random_series(RANDOM_ITEMS);
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    run_random_series(RANDOM_ITEMS);
    wait_drained();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_random_series(RANDOM_ITEMS);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_series();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_series();
    test_zero_values();
    test_zero_reciprocal();
    test_mean_overflow();
    wait_drained();
    test_total_saturation();
    wait_drained();
    test_random_traffic();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/whm_pkg.sv
hw/rtl/whm_div.sv
hw/rtl/weighted_harmonic_mean.sv
test/tb_weighted_harmonic_mean.sv
